[src/assert_macros.svh]
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle check, masked while reset is applied.
`define CPM_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Trigger in one cycle, consequence in the next.
`define CPM_ASSERT_NEXT(label, clk, rst_n, trig, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
    else $error(msg);

`endif

[src/cpm_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package cpm_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned LEN_W  = 5;
  localparam int unsigned IDX_W  = 4;
  // highest pattern position the index field can reach, plus one
  localparam int unsigned IDX_SPAN = 16;

  typedef enum logic {
    KIND_PATTERN = 1'b0,
    KIND_TEXT    = 1'b1
  } kind_e;

  typedef logic signed [WORD_W-1:0] word_t;

  typedef struct packed {
    logic found;
  } result_t;

endpackage
`default_nettype wire

[src/cpm_cell.sv]
`timescale 1ns / 1ps
`default_nettype none
module cpm_cell (
  input  logic           clk_i,
  input  logic           shift_i,
  input  cpm_pkg::word_t word_i,
  input  cpm_pkg::word_t pat_i,
  output cpm_pkg::word_t word_o,
  output logic           eq_o
);
  import cpm_pkg::*;

  word_t word_q;

  // compare the word about to land here, so the match sees the shifted window
  assign eq_o   = (word_i == pat_i);
  assign word_o = word_q;

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      word_q <= word_i;
    end
  end

endmodule
`default_nettype wire

[src/cpm_out_fifo.sv]
`timescale 1ns / 1ps
`default_nettype none
module cpm_out_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  cpm_pkg::result_t push_item_i,
  input  logic             pop_i,
  output logic             valid_o,
  output logic             full_o,
  output cpm_pkg::result_t item_o
);
  import cpm_pkg::*;

  result_t    entries_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;

  assign valid_o = (count_q != 2'd0);
  assign full_o  = (count_q == 2'd2);
  assign item_o  = entries_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i  ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule
`default_nettype wire

[src/contiguous_pattern_matcher.sv]
`timescale 1ns / 1ps
`default_nettype none
// Contiguous pattern matcher: tells whether the stored pattern occurs as an
// unbroken run inside a text stream.
// Input channel (in_valid_i / in_stall_o): kind 0 items write one pattern word
// at pattern_index_i, kind 1 items present one text word; last_i closes a text.
// cfg_we_i / cfg_wdata_i set pattern_length (0 = empty pattern, always matches).
// Throughput: one item per cycle while in_stall_o is low. Each text word shifts
// through a row of MAX_PATTERN window cells and every cell compares in the same
// cycle, so the combinational compare-and-reduce across the row sets the rate.
// Non-last words and pattern writes give no item. A text's found item is queued
// as its last word is taken and shows on out_valid_o / found_o in order.
// Receiver stall: results queue in a two-entry output buffer; input keeps
// flowing while one result waits, and in_stall_o rises only when both are full.
// Reset: word count, sticky match flag, output buffer and pattern_length clear;
// pattern words hold garbage until written.
module contiguous_pattern_matcher #(
  parameter int unsigned MAX_PATTERN = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        kind_i,
  input  logic [cpm_pkg::IDX_W-1:0]   pattern_index_i,
  input  cpm_pkg::word_t              word_value_i,
  input  logic                        last_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        found_o,
  input  logic                        cfg_we_i,
  input  logic [cpm_pkg::LEN_W-1:0]   cfg_wdata_i
);
  import cpm_pkg::*;

  // count range 0..MAX_PATTERN
  localparam int unsigned CW = $clog2(MAX_PATTERN + 1);
  localparam logic [CW-1:0] MaxCnt = CW'(MAX_PATTERN);
  // only positions reachable by the index field need storage
  localparam int unsigned PS = (MAX_PATTERN < IDX_SPAN) ? MAX_PATTERN : IDX_SPAN;

  logic [LEN_W-1:0] len_q;
  word_t            pattern_q [PS];
  logic [CW-1:0]    seen_q, seen_d;
  logic             match_q, match_d;
  logic [CW-1:0]    used_len;

  word_t            cell_in  [MAX_PATTERN];
  word_t            cell_out [MAX_PATTERN];
  word_t            pat_sel  [MAX_PATTERN];
  logic [MAX_PATTERN-1:0] eq, in_use;

  logic    in_acc, text_acc, pat_acc;
  logic    match_now;
  logic    push;
  result_t push_item, head_item;
  logic    fifo_full;

  assign in_acc   = in_valid_i && !in_stall_o;
  assign text_acc = in_acc && (kind_i == KIND_TEXT);
  assign pat_acc  = in_acc && (kind_i == KIND_PATTERN);
  assign in_stall_o = fifo_full;

  // lengths above capacity act as a full-width pattern
  always_comb begin
    if (int'(len_q) > int'(MAX_PATTERN)) begin
      used_len = MaxCnt;
    end else begin
      used_len = CW'(len_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= '0;
    end else if (cfg_we_i) begin
      len_q <= cfg_wdata_i;
    end
  end

  // pattern store; writes past capacity fall through
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < int'(PS); k++) begin
      if (pat_acc && (int'(pattern_index_i) == k)) begin
        pattern_q[k] <= word_value_i;
      end
    end
  end

  // Window row: cell 0 holds the newest word. Cell j lines up with pattern
  // position used_len-1-j, so the oldest word in the run meets pattern word 0.
  for (genvar j = 0; j < int'(MAX_PATTERN); j++) begin : g_cell
    if (j == 0) begin : g_head
      assign cell_in[j] = word_value_i;
    end else begin : g_link
      assign cell_in[j] = cell_out[j-1];
    end

    always_comb begin
      pat_sel[j] = '0;
      for (int k = 0; k < int'(PS); k++) begin
        if (int'(used_len) == j + k + 1) begin
          pat_sel[j] = pattern_q[k];
        end
      end
    end

    assign in_use[j] = (int'(used_len) > j);

    cpm_cell u_cell (
      .clk_i  (clk_i),
      .shift_i(text_acc),
      .word_i (cell_in[j]),
      .pat_i  (pat_sel[j]),
      .word_o (cell_out[j]),
      .eq_o   (eq[j])
    );
  end

  // the word count guards stale cells, so the window itself is never cleared
  always_comb begin
    seen_d    = seen_q;
    match_d   = match_q;
    push      = 1'b0;
    push_item.found = 1'b0;
    match_now = 1'b0;
    if (text_acc) begin
      seen_d = (seen_q < MaxCnt) ? seen_q + CW'(1) : seen_q;
      // empty pattern: count check and cell check both pass trivially
      match_now = (seen_d >= used_len) && (&(eq | ~in_use));
      if (last_i) begin
        push            = 1'b1;
        push_item.found = match_q || match_now;
        seen_d          = '0;
        match_d         = 1'b0;
      end else begin
        match_d = match_q || match_now;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q  <= '0;
      match_q <= 1'b0;
    end else begin
      seen_q  <= seen_d;
      match_q <= match_d;
    end
  end

  cpm_out_fifo u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_item_i(push_item),
    .pop_i      (out_valid_o && !out_stall_i),
    .valid_o    (out_valid_o),
    .full_o     (fifo_full),
    .item_o     (head_item)
  );

  assign found_o = head_item.found;

`include "assert_macros.svh"

  `CPM_ASSERT(a_stall_has_result, clk_i, rst_ni, !in_stall_o || out_valid_o, "stall without queued result")
  `CPM_ASSERT_NEXT(a_last_gives_result, clk_i, rst_ni, text_acc && last_i, out_valid_o, "last word gave no result")
  `CPM_ASSERT_NEXT(a_pattern_keeps_count, clk_i, rst_ni, pat_acc, $stable(seen_q) && $stable(match_q), "pattern write moved text state")
  `CPM_ASSERT(a_count_bound, clk_i, rst_ni, seen_q <= MaxCnt, "word count past capacity")

endmodule
`default_nettype wire
